[design/anxb_pkg.sv]
package anxb_pkg;

	localparam int CAP_W = 21;
	localparam logic [CAP_W-1:0] CAP_RESET = 21'd65536;

	// Result kinds
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_DATA   = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	// Error codes
	localparam logic ERR_FORBIDDEN = 1'b0;
	localparam logic ERR_OVER_CAP  = 1'b1;

	typedef struct packed {
		logic [7:0] stream_byte;
		logic       end_of_stream;
	} anxb_in_t;

	typedef struct packed {
		logic [1:0]       result_kind;
		logic [7:0]       data_byte;
		logic [1:0]       ref_priority;
		logic [4:0]       unit_type;
		logic [CAP_W-1:0] payload_length;
		logic             error_code;
		logic             last_of_run;
	} anxb_res_t;

	// Results caused by one byte, always in this order:
	// header (or forbidden error), zeros, byte, over-capacity error, end of unit.
	typedef struct packed {
		logic             has_head;
		logic             head_bad;
		logic [1:0]       ref_priority;
		logic [4:0]       unit_type;
		logic [2:0]       zero_cnt;
		logic             has_byte;
		logic [7:0]       byte_val;
		logic             has_ovf;
		logic             has_end;
		logic [CAP_W-1:0] end_len;
	} anxb_cmd_t;

endpackage

[design/annexb_nal_unit_extractor_top.sv]
// Annex B unit extractor. Takes one stream byte per request and finds 00 00 01
// and 00 00 00 01 start codes. Each unit gives a header result, its payload
// bytes with emulation-prevention 03 bytes removed, and an end result with the
// payload length; a set forbidden bit or a payload beyond payload_capacity
// gives an error result and a return to start-code search. The front stage
// classifies every byte in the cycle it is accepted and, if it causes any
// result, queues one request describing all of them (up to five); the back
// stage plays a request out at one result per cycle while res_ready allows,
// into a registered output. A byte is accepted every cycle while the queue
// (QUEUE_DEPTH deep) has room, so bytes that cause no result or a single one
// stream at one per cycle; a byte causing several results holds the back stage
// until all are out, which bounds the sustained rate on zeros before data. Write
// payload_capacity through cfg_we/cfg_data only while the block is idle.
module annexb_nal_unit_extractor_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       byte_valid,
	output logic                       byte_ready,
	input  anxb_pkg::anxb_in_t         byte_item,
	output logic                       res_valid,
	input  logic                       res_ready,
	output anxb_pkg::anxb_res_t        res_item,
	input  logic                       cfg_we,
	input  logic [anxb_pkg::CAP_W-1:0] cfg_data
);

	logic [anxb_pkg::CAP_W-1:0] capacity_q;
	logic                       q_full;
	logic                       q_not_empty;
	logic                       q_pop;
	logic                       cmd_push;
	anxb_pkg::anxb_cmd_t        cmd;
	anxb_pkg::anxb_cmd_t        q_head;
	logic                       accept;

	// Hold the capacity register; write it straight from the port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= anxb_pkg::CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_data;
		end
	end

	// Accept a byte whenever the queue can take whatever it causes
	assign byte_ready = !q_full;
	assign accept     = byte_valid && byte_ready;

	anxb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.byte_item (byte_item),
		.capacity  (capacity_q),
		.cmd_push  (cmd_push),
		.cmd       (cmd)
	);

	anxb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// Advance through each queued request one result per cycle while res_ready allows
	anxb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_not_empty),
		.q_data    (q_head),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

endmodule

[design/anxb_front.sv]
module anxb_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  anxb_pkg::anxb_in_t         byte_item,
	input  logic [anxb_pkg::CAP_W-1:0] capacity,
	output logic                       cmd_push,
	output anxb_pkg::anxb_cmd_t        cmd
);

	typedef enum logic [1:0] {
		PH_SEARCH,
		PH_HEADER,
		PH_PAYLOAD
	} phase_t;

	phase_t                     phase_q, phase_n;
	logic [1:0]                 held_q, held_n;
	logic                       hzh_q, hzh_n;
	logic [1:0]                 zrun_q, zrun_n;
	logic [anxb_pkg::CAP_W-1:0] cnt_q, cnt_n;

	logic [7:0]                 b;
	logic                       eos;
	logic [anxb_pkg::CAP_W:0]   diff;
	logic [2:0]                 avail;
	logic                       zz;
	logic [1:0]                 held_z;
	logic                       hzh_z;
	logic [2:0]                 z_tot;
	logic [1:0]                 nreal;
	logic [1:0]                 zr;
	logic [2:0]                 emitted;

	function automatic logic [1:0] sat_add(input logic [1:0] run, input logic [2:0] n);
		logic [3:0] s;
		s = {2'b00, run} + {1'b0, n};
		return (s >= 4'd2) ? 2'd2 : s[1:0];
	endfunction

	assign b   = byte_item.stream_byte;
	assign eos = byte_item.end_of_stream;

	// Room left in the unit, clipped to the most zeros plus byte one request can take
	assign diff = {1'b0, capacity} - {1'b0, cnt_q};
	always_comb begin
		if (diff[anxb_pkg::CAP_W] || (diff == '0)) begin
			avail = 3'd0;
		end else if (diff >= (anxb_pkg::CAP_W+1)'(5)) begin
			avail = 3'd5;
		end else begin
			avail = diff[2:0];
		end
	end

	always_comb begin
		cmd     = '0;
		phase_n = phase_q;
		held_n  = held_q;
		hzh_n   = hzh_q;
		zrun_n  = zrun_q;
		cnt_n   = cnt_q;
		zz      = 1'b0;
		held_z  = held_q;
		hzh_z   = hzh_q;
		z_tot   = 3'd0;
		nreal   = held_q - {1'b0, hzh_q};
		zr      = zrun_q;
		emitted = 3'd0;
		case (phase_q)
			PH_HEADER: begin
				cmd.has_head = 1'b1;
				held_n       = 2'd0;
				hzh_n        = 1'b0;
				zrun_n       = 2'd0;
				cnt_n        = '0;
				if (b[7]) begin
					cmd.head_bad = 1'b1;
					phase_n      = PH_SEARCH;
				end else begin
					cmd.ref_priority = b[6:5];
					cmd.unit_type    = b[4:0];
					phase_n          = PH_PAYLOAD;
					if (b == 8'h00) begin
						held_n = 2'd1;
						hzh_n  = 1'b1;
					end
					if (eos) begin
						cmd.has_end = 1'b1;
					end
				end
			end
			PH_PAYLOAD: begin
				if (b == 8'h00) begin
					zz     = (held_q == 2'd3) && !hzh_q;
					held_z = (held_q == 2'd3) ? 2'd3 : held_q + 2'd1;
					hzh_z  = hzh_q && (held_q != 2'd3);
					z_tot  = {2'b00, zz} +
						(eos ? ({1'b0, held_z} - {2'b00, hzh_z}) : 3'd0);
					if (z_tot > avail) begin
						cmd.zero_cnt = avail;
						cmd.has_ovf  = 1'b1;
						phase_n      = PH_SEARCH;
						held_n       = 2'd3;
						hzh_n        = 1'b0;
						zrun_n       = 2'd0;
						cnt_n        = '0;
					end else begin
						cmd.zero_cnt = z_tot;
						cnt_n        = cnt_q + anxb_pkg::CAP_W'(z_tot);
						zrun_n       = sat_add(zrun_q, z_tot);
						held_n       = held_z;
						hzh_n        = hzh_z;
						if (eos) begin
							cmd.has_end = 1'b1;
							cmd.end_len = cnt_n;
						end
					end
				end else if ((b == 8'h01) && (held_q >= 2'd2)) begin
					cmd.has_end = 1'b1;
					cmd.end_len = cnt_q;
					phase_n     = PH_HEADER;
					held_n      = 2'd0;
					hzh_n       = 1'b0;
					zrun_n      = 2'd0;
					cnt_n       = '0;
				end else begin
					held_n = 2'd0;
					hzh_n  = 1'b0;
					if ({1'b0, nreal} > avail) begin
						cmd.zero_cnt = avail;
						cmd.has_ovf  = 1'b1;
					end else begin
						cmd.zero_cnt = {1'b0, nreal};
						zr           = sat_add(zrun_q, {1'b0, nreal});
						if ((b == 8'h03) && (zr == 2'd2)) begin
							// drop the emulation-prevention byte
							emitted = {1'b0, nreal};
						end else if (avail == {1'b0, nreal}) begin
							cmd.has_ovf = 1'b1;
						end else begin
							cmd.has_byte = 1'b1;
							cmd.byte_val = b;
							emitted      = {1'b0, nreal} + 3'd1;
						end
					end
					if (cmd.has_ovf) begin
						phase_n = PH_SEARCH;
						zrun_n  = 2'd0;
						cnt_n   = '0;
					end else begin
						zrun_n = 2'd0;
						cnt_n  = cnt_q + anxb_pkg::CAP_W'(emitted);
						if (eos) begin
							cmd.has_end = 1'b1;
							cmd.end_len = cnt_n;
						end
					end
				end
			end
			default: begin
				if (b == 8'h00) begin
					held_n = (held_q == 2'd3) ? 2'd3 : held_q + 2'd1;
				end else if ((b == 8'h01) && (held_q >= 2'd2)) begin
					phase_n = PH_HEADER;
					held_n  = 2'd0;
					hzh_n   = 1'b0;
					zrun_n  = 2'd0;
					cnt_n   = '0;
				end else begin
					held_n = 2'd0;
				end
			end
		endcase
		if (eos) begin
			phase_n = PH_SEARCH;
			held_n  = 2'd0;
			hzh_n   = 1'b0;
			zrun_n  = 2'd0;
			cnt_n   = '0;
		end
	end

	assign cmd_push = accept && (cmd.has_head || cmd.has_byte || cmd.has_ovf ||
		cmd.has_end || (cmd.zero_cnt != 3'd0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			held_q  <= 2'd0;
			hzh_q   <= 1'b0;
			zrun_q  <= 2'd0;
			cnt_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			held_q  <= held_n;
			hzh_q   <= hzh_n;
			zrun_q  <= zrun_n;
			cnt_q   <= cnt_n;
		end
	end

endmodule

[design/anxb_queue.sv]
module anxb_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  anxb_pkg::anxb_cmd_t push_data,
	input  logic                pop,
	output logic                full,
	output logic                not_empty,
	output anxb_pkg::anxb_cmd_t head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	anxb_pkg::anxb_cmd_t slot_q [DEPTH];
	logic [PTR_W-1:0]    wr_q, rd_q;
	logic [CNT_W-1:0]    cnt_q;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[design/anxb_back.sv]
module anxb_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  anxb_pkg::anxb_cmd_t q_data,
	output logic                q_pop,
	output logic                res_valid,
	input  logic                res_ready,
	output anxb_pkg::anxb_res_t res_item
);

	anxb_pkg::anxb_cmd_t cur_q;
	logic                cur_valid_q;
	anxb_pkg::anxb_cmd_t rest;
	anxb_pkg::anxb_res_t res_n;
	anxb_pkg::anxb_res_t res_q;
	logic                res_valid_q;
	logic                rest_empty;
	logic                emit;

	// Pick the next result of the current request and strip it off
	always_comb begin
		rest  = cur_q;
		res_n = '0;
		if (cur_q.has_head) begin
			rest.has_head = 1'b0;
			if (cur_q.head_bad) begin
				res_n.result_kind = anxb_pkg::KIND_ERROR;
				res_n.error_code  = anxb_pkg::ERR_FORBIDDEN;
			end else begin
				res_n.result_kind  = anxb_pkg::KIND_HEADER;
				res_n.ref_priority = cur_q.ref_priority;
				res_n.unit_type    = cur_q.unit_type;
			end
		end else if (cur_q.zero_cnt != 3'd0) begin
			rest.zero_cnt     = cur_q.zero_cnt - 3'd1;
			res_n.result_kind = anxb_pkg::KIND_DATA;
		end else if (cur_q.has_byte) begin
			rest.has_byte     = 1'b0;
			res_n.result_kind = anxb_pkg::KIND_DATA;
			res_n.data_byte   = cur_q.byte_val;
		end else if (cur_q.has_ovf) begin
			rest.has_ovf      = 1'b0;
			res_n.result_kind = anxb_pkg::KIND_ERROR;
			res_n.error_code  = anxb_pkg::ERR_OVER_CAP;
		end else begin
			rest.has_end         = 1'b0;
			res_n.result_kind    = anxb_pkg::KIND_END;
			res_n.payload_length = cur_q.end_len;
		end
		rest_empty = !rest.has_head && (rest.zero_cnt == 3'd0) && !rest.has_byte &&
			!rest.has_ovf && !rest.has_end;
		res_n.last_of_run = rest_empty;
	end

	assign emit  = cur_valid_q && (!res_valid_q || res_ready);
	assign q_pop = q_valid && (!cur_valid_q || (emit && rest_empty));

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end else if (emit) begin
			cur_q <= rest;
		end
		if (emit) begin
			res_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
			end else if (emit && rest_empty) begin
				cur_valid_q <= 1'b0;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	// Bytes of the stream that carry meaning for the parser
	localparam logic [7:0] ZERO_BYTE     = 8'h00;
	localparam logic [7:0] START_MARK    = 8'h01;
	localparam logic [7:0] EMU_PREVENT   = 8'h03;
	localparam logic [7:0] FORBIDDEN_BIT = 8'h80;
	localparam logic [7:0] TYPE_MASK     = 8'h1F;

	localparam int MAX_PER_BYTE  = 5;
	localparam int RANDOM_ITEMS  = 60;
	localparam int RX_LONG_HOLD  = 200;
	localparam int DRAIN_CYCLES  = 60;
	localparam longint TIMEOUT_NS = 64'd10_000_000;

	typedef enum logic [1:0] {
		SCAN_SEARCH  = 2'd0,
		SCAN_HEADER  = 2'd1,
		SCAN_PAYLOAD = 2'd2
	} scan_phase_t;

	logic                     clk;
	logic                     arst_n;
	logic                     byte_valid;
	logic                     byte_ready;
	anxb_pkg::anxb_in_t       byte_item;
	logic                     res_valid;
	logic                     res_ready;
	anxb_pkg::anxb_res_t      res_item;
	logic                     cfg_we;
	logic [anxb_pkg::CAP_W-1:0] cfg_data;

	// Parser state mirrored by the testbench
	scan_phase_t                scan_state;
	logic [1:0]                 zeros_held;
	logic                       header_zero;
	logic [1:0]                 payload_zeros;
	logic [anxb_pkg::CAP_W-1:0] unit_bytes;
	logic [anxb_pkg::CAP_W-1:0] capacity;

	anxb_pkg::anxb_res_t step_results[$];
	anxb_pkg::anxb_res_t awaited_results[$];

	int unsigned errors;
	int unsigned bytes_sent;
	bit          tx_steady;
	bit          rx_steady;
	bit          rx_hold_pending;

	annexb_nal_unit_extractor_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_item   (res_item),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Stream parser prediction
	// ---------------------------------------------------------------------

	// Drop everything that belongs to the unit in progress
	function automatic void clear_unit_state();
		zeros_held    = 2'd0;
		header_zero   = 1'b0;
		payload_zeros = 2'd0;
		unit_bytes    = '0;
	endfunction

	function automatic void reset_predictor();
		capacity   = anxb_pkg::CAP_RESET;
		scan_state = SCAN_SEARCH;
		clear_unit_state();
	endfunction

	// Give up on the unit and go back to hunting for a start code, keeping
	// any zeros that may still open the next one
	function automatic void abandon_unit(input logic [1:0] keep);
		clear_unit_state();
		zeros_held = keep;
		scan_state = SCAN_SEARCH;
	endfunction

	function automatic void add_result(input logic [1:0] kind, input logic [7:0] data,
			input logic [1:0] ref_prio, input logic [4:0] utype,
			input logic [anxb_pkg::CAP_W-1:0] len, input logic err);
		anxb_pkg::anxb_res_t r;
		if (step_results.size() >= MAX_PER_BYTE)
			return;
		r                = '0;
		r.result_kind    = kind;
		r.data_byte      = data;
		r.ref_priority   = ref_prio;
		r.unit_type      = utype;
		r.payload_length = len;
		r.error_code     = err;
		step_results.push_back(r);
	endfunction

	// One payload byte; a 03 after two zeros is stripped. Returns 0 on overflow.
	function automatic logic put_payload(input logic [7:0] value);
		if (value == EMU_PREVENT && payload_zeros >= 2'd2) begin
			payload_zeros = 2'd0;
			return 1'b1;
		end
		if (unit_bytes >= capacity) begin
			add_result(anxb_pkg::KIND_ERROR, 8'h00, 2'd0, 5'd0, '0, anxb_pkg::ERR_OVER_CAP);
			return 1'b0;
		end
		add_result(anxb_pkg::KIND_DATA, value, 2'd0, 5'd0, '0, 1'b0);
		unit_bytes = unit_bytes + anxb_pkg::CAP_W'(1);
		if (value == ZERO_BYTE) begin
			if (payload_zeros < 2'd2)
				payload_zeros = payload_zeros + 2'd1;
		end else begin
			payload_zeros = 2'd0;
		end
		return 1'b1;
	endfunction

	// Release held zeros as payload; a held header zero is skipped
	function automatic logic flush_zeros();
		int n;
		n = int'(zeros_held);
		zeros_held = 2'd0;
		for (int i = 0; i < n; i++) begin
			if (header_zero)
				header_zero = 1'b0;
			else if (!put_payload(ZERO_BYTE))
				return 1'b0;
		end
		header_zero = 1'b0;
		return 1'b1;
	endfunction

	// Work out every result that one accepted byte causes and queue them
	function automatic void parse_stream_byte(input anxb_pkg::anxb_in_t item);
		logic [7:0]          b;
		anxb_pkg::anxb_res_t r;
		int                  n;
		b = item.stream_byte;
		step_results.delete();
		case (scan_state)
			SCAN_HEADER: begin
				if ((b & FORBIDDEN_BIT) != 8'h00) begin
					add_result(anxb_pkg::KIND_ERROR, 8'h00, 2'd0, 5'd0, '0,
						anxb_pkg::ERR_FORBIDDEN);
					abandon_unit(2'd0);
				end else begin
					add_result(anxb_pkg::KIND_HEADER, 8'h00, b[6:5], 5'(b & TYPE_MASK), '0,
						1'b0);
					clear_unit_state();
					scan_state = SCAN_PAYLOAD;
					if (b == ZERO_BYTE) begin
						zeros_held  = 2'd1;
						header_zero = 1'b1;
					end
				end
			end
			SCAN_PAYLOAD: begin
				if (b == ZERO_BYTE) begin
					if (zeros_held == 2'd3) begin
						if (header_zero)
							header_zero = 1'b0;
						else if (!put_payload(ZERO_BYTE))
							abandon_unit(2'd3);
					end else begin
						zeros_held = zeros_held + 2'd1;
					end
				end else if (b == START_MARK && zeros_held >= 2'd2) begin
					add_result(anxb_pkg::KIND_END, 8'h00, 2'd0, 5'd0, unit_bytes, 1'b0);
					clear_unit_state();
					scan_state = SCAN_HEADER;
				end else if (!flush_zeros() || !put_payload(b)) begin
					abandon_unit(2'd0);
				end
			end
			default: begin
				if (b == ZERO_BYTE) begin
					if (zeros_held != 2'd3)
						zeros_held = zeros_held + 2'd1;
				end else if (b == START_MARK && zeros_held >= 2'd2) begin
					clear_unit_state();
					scan_state = SCAN_HEADER;
				end else begin
					zeros_held = 2'd0;
				end
			end
		endcase

		// End of stream closes any open unit, then everything starts afresh
		if (item.end_of_stream) begin
			if (scan_state == SCAN_PAYLOAD && flush_zeros())
				add_result(anxb_pkg::KIND_END, 8'h00, 2'd0, 5'd0, unit_bytes, 1'b0);
			clear_unit_state();
			scan_state = SCAN_SEARCH;
		end

		n = step_results.size();
		for (int i = 0; i < n; i++) begin
			r = step_results[i];
			r.last_of_run = (i == n - 1);
			awaited_results.push_back(r);
		end
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------

	// Mostly short pauses, now and then a long one
	function automatic int unsigned idle_len();
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(12, 40);
		return $urandom_range(1, 3);
	endfunction

	// Offer one byte as a request and hold it until the block takes it.
	// Valid is only lowered here when a pause goes in front of the request,
	// so back-to-back requests keep it high.
	task automatic send_byte(input logic [7:0] value, input logic eos);
		anxb_pkg::anxb_in_t item;
		int unsigned gap;
		item.stream_byte   = value;
		item.end_of_stream = eos;
		gap = (tx_steady || $urandom_range(0, 1) == 0) ? 0 : idle_len();
		if (gap != 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item  <= item;
		parse_stream_byte(item);
		bytes_sent++;
		@(posedge clk);
		while (!byte_ready)
			@(posedge clk);
	endtask

	task automatic send_start(input bit four_bytes);
		if (four_bytes)
			send_byte(ZERO_BYTE, 1'b0);
		send_byte(ZERO_BYTE, 1'b0);
		send_byte(ZERO_BYTE, 1'b0);
		send_byte(START_MARK, 1'b0);
	endtask

	// Drop valid and wait until every awaited result has come, then a little
	// longer in case a byte is still in flight without a result of its own
	task automatic wait_drained();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [anxb_pkg::CAP_W-1:0] value);
		wait_drained();
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
		capacity = value;
	endtask

	// Payload content biased towards the bytes that matter to the parser
	function automatic logic [7:0] payload_value();
		case ($urandom_range(0, 9))
			0, 1, 2: return ZERO_BYTE;
			3:       return EMU_PREVENT;
			4:       return START_MARK;
			default: return 8'($urandom);
		endcase
	endfunction

	// One unit with random content, sometimes with junk or a broken start
	// code in front and sometimes closed by end of stream
	task automatic send_random_unit();
		logic [7:0] head;
		int unsigned len;
		bit eos_end;
		if ($urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(1, 3))
				send_byte(($urandom_range(0, 1) != 0) ? ZERO_BYTE : 8'($urandom),
					($urandom_range(0, 15) == 0));
		end
		send_start($urandom_range(0, 1) != 0);
		head = 8'($urandom);
		if ($urandom_range(0, 9) != 0)
			head[7] = 1'b0;
		if ($urandom_range(0, 15) == 0)
			head = ZERO_BYTE;
		len = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 7);
		eos_end = ($urandom_range(0, 7) == 0);
		send_byte(head, eos_end && len == 0);
		for (int i = 0; i < len; i++)
			send_byte(payload_value(), eos_end && i == len - 1);
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Header fields, extreme bytes, emulation prevention, long zero runs,
	// a forbidden header and a unit closed by the next start code
	task automatic test_unit_basics();
		send_start(1'b1);
		send_byte(8'h65, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(ZERO_BYTE, 1'b0);
		send_byte(ZERO_BYTE, 1'b0);
		send_byte(EMU_PREVENT, 1'b0);
		send_byte(START_MARK, 1'b0);
		repeat (4) send_byte(ZERO_BYTE, 1'b0);
		send_byte(8'h07, 1'b0);
		send_start(1'b0);
		send_byte(8'h9F, 1'b0);
		send_start(1'b0);
		send_byte(8'h1F, 1'b0);
		send_byte(8'h80, 1'b0);
		// A zero header held with the zeros that open the next start code
		send_start(1'b0);
		send_byte(ZERO_BYTE, 1'b0);
		send_start(1'b0);
		send_byte(8'h7E, 1'b0);
		wait_drained();
	endtask

	// Units cut short by the last byte of the stream
	task automatic test_end_of_stream();
		send_start(1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(ZERO_BYTE, 1'b0);
		send_byte(ZERO_BYTE, 1'b1);
		send_byte(ZERO_BYTE, 1'b0);
		send_byte(ZERO_BYTE, 1'b0);
		send_byte(START_MARK, 1'b1);
		send_start(1'b0);
		send_byte(ZERO_BYTE, 1'b1);
		// Three held zeros, the byte and the end all from one request
		send_start(1'b1);
		send_byte(8'h2A, 1'b0);
		send_byte(EMU_PREVENT, 1'b0);
		repeat (3) send_byte(ZERO_BYTE, 1'b0);
		send_byte(8'h07, 1'b1);
		wait_drained();
	endtask

	// Overflow with small limits, a zero limit and a large limit
	task automatic test_capacity_limits();
		set_capacity(21'd2);
		send_start(1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'hBB, 1'b0);
		send_byte(8'hCC, 1'b0);
		set_capacity(21'd1);
		send_start(1'b0);
		send_byte(8'h41, 1'b0);
		// Overflow on a zero keeps the held zeros, so 01 opens a unit at once
		repeat (5) send_byte(ZERO_BYTE, 1'b0);
		send_byte(START_MARK, 1'b0);
		send_byte(8'h25, 1'b0);
		send_byte(8'h07, 1'b1);
		set_capacity(21'd0);
		send_start(1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_start(1'b0);
		send_byte(ZERO_BYTE, 1'b0);
		send_start(1'b0);
		send_byte(8'h22, 1'b0);
		send_byte(ZERO_BYTE, 1'b1);
		set_capacity(21'd1048576);
		send_start(1'b1);
		send_byte(8'h45, 1'b0);
		repeat (6) send_byte(8'($urandom), 1'b0);
		set_capacity(anxb_pkg::CAP_RESET);
	endtask

	// Hold the receiver off while the sender keeps offering, so the block
	// fills up and has to stall its input
	task automatic test_backpressure();
		wait_drained();
		rx_steady = 1'b1;
		tx_steady = 1'b1;
		rx_hold_pending = 1'b1;
		@(posedge clk);
		send_start(1'b1);
		send_byte(8'h65, 1'b0);
		repeat (30) send_byte(payload_value(), 1'b0);
		send_start(1'b0);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		wait_drained();
	endtask

	// A stretch with no pauses on either side
	task automatic test_full_rate();
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		repeat (3) send_random_unit();
		wait_drained();
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// Random units, changing the limit now and then while the block is idle
	task automatic test_random_stream();
		int unsigned target;
		int unsigned units;
		target = bytes_sent + RANDOM_ITEMS;
		units  = 0;
		while (bytes_sent < target) begin
			send_random_unit();
			units++;
			if (units % 3 == 0) begin
				case ($urandom_range(0, 5))
					0:       set_capacity(21'd1);
					1:       set_capacity(21'd1048576);
					2:       set_capacity(anxb_pkg::CAP_RESET);
					default: set_capacity(anxb_pkg::CAP_W'($urandom_range(2, 12)));
				endcase
			end
		end
		wait_drained();
	endtask

	// ---------------------------------------------------------------------
	// Result side
	// ---------------------------------------------------------------------

	// Ready with random stalls; a requested long hold-off is counted here
	initial begin : result_receiver
		res_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_pending) begin
				rx_hold_pending = 1'b0;
				res_ready <= 1'b0;
				repeat (RX_LONG_HOLD) @(posedge clk);
			end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
				res_ready <= 1'b0;
				repeat (idle_len()) @(posedge clk);
			end else begin
				res_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Compare every result taken with the oldest one awaited
	always @(posedge clk) begin : result_checker
		anxb_pkg::anxb_res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, res_item);
				errors++;
			end else begin
				want = awaited_results.pop_front();
				check_field("result_kind", 32'(want.result_kind), 32'(res_item.result_kind));
				check_field("data_byte", 32'(want.data_byte), 32'(res_item.data_byte));
				check_field("ref_priority", 32'(want.ref_priority),
					32'(res_item.ref_priority));
				check_field("unit_type", 32'(want.unit_type), 32'(res_item.unit_type));
				check_field("payload_length", 32'(want.payload_length),
					32'(res_item.payload_length));
				check_field("error_code", 32'(want.error_code), 32'(res_item.error_code));
				check_field("last_of_run", 32'(want.last_of_run), 32'(res_item.last_of_run));
			end
		end
	end

	// ---------------------------------------------------------------------
	// Sequence of tests
	// ---------------------------------------------------------------------

	initial begin
		errors          = 0;
		bytes_sent      = 0;
		tx_steady       = 1'b0;
		rx_steady       = 1'b0;
		rx_hold_pending = 1'b0;
		reset_predictor();
		arst_n     <= 1'b0;
		byte_valid <= 1'b0;
		byte_item  <= '0;
		cfg_we     <= 1'b0;
		cfg_data   <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unit_basics();
		test_end_of_stream();
		test_capacity_limits();
		test_backpressure();
		test_full_rate();
		test_random_stream();
		wait_drained();

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Stop a run that has hung
	initial begin
		#(TIMEOUT_NS);
		$display("Some tests failed");
		$finish;
	end

endmodule
